// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the sorted deadline timer queue.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("timer queue check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer queue check failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/sdtq_pkg.sv =====
// Package of the sorted deadline timer queue: sizes, codes and the
// structs between sequencer, compare unit and entry store. No dependencies.
`default_nettype none
package sdtq_pkg;

    localparam int DEPTH      = 16;
    localparam int TIME_WIDTH = 32;
    localparam int ID_WIDTH   = 16;
    localparam int MAX_OUT    = 16;
    localparam int DELAY_W    = 31;
    localparam int IN_ID_W    = 16;
    localparam int POS_W      = 5;
    localparam int RK_W       = 2;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int N_W        = $clog2(MAX_OUT + 1);

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [RK_W-1:0] RK_ACCEPT = 2'd0;
    localparam logic [RK_W-1:0] RK_REJECT = 2'd1;
    localparam logic [RK_W-1:0] RK_EXPIRE = 2'd2;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SCAN   = 7'b0000010,
        ST_INSERT = 7'b0000100,
        ST_ACK    = 7'b0001000,
        ST_ZEXP   = 7'b0010000,
        ST_REJ    = 7'b0100000,
        ST_TSCAN  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic                  insert;
        logic                  drop;
        logic [CNT_W-1:0]      pos;
        logic [IDX_W-1:0]      rd_idx;
        logic [TIME_WIDTH-1:0] wr_deadline;
        logic [ID_WIDTH-1:0]   wr_id;
    } store_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0]      count;
        logic [TIME_WIDTH-1:0] rd_deadline;
        logic [ID_WIDTH-1:0]   head_id;
    } store_stat_t;

    typedef struct packed {
        logic zero;
        logic le;
    } cmp_flags_t;

endpackage
`default_nettype wire

// ===== rtl/sdtq_cmp.sv =====
// Shared compare unit: remaining time of one entry (deadline minus now)
// checked against a limit and against zero. Uses sdtq_pkg.
`default_nettype none
module sdtq_cmp (
    input  wire logic [sdtq_pkg::TIME_WIDTH-1:0] deadline,
    input  wire logic [sdtq_pkg::TIME_WIDTH-1:0] now,
    input  wire logic [sdtq_pkg::TIME_WIDTH-1:0] limit,
    output sdtq_pkg::cmp_flags_t                 flags
);

    logic [sdtq_pkg::TIME_WIDTH-1:0] remain;

    always_comb
    begin
        remain     = deadline - now;
        flags.zero = (remain == '0);
        flags.le   = (remain <= limit);
    end

endmodule
`default_nettype wire

// ===== rtl/sdtq_store.sv =====
// Sorted entry store: deadlines and ids with insert-at-position, drop-front
// and one indexed deadline read. Uses sdtq_pkg.
`default_nettype none
module sdtq_store (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sdtq_pkg::store_cmd_t  cmd,
    output sdtq_pkg::store_stat_t stat
);

    logic [sdtq_pkg::TIME_WIDTH-1:0] dl_reg [sdtq_pkg::DEPTH];
    logic [sdtq_pkg::ID_WIDTH-1:0]   id_reg [sdtq_pkg::DEPTH];
    logic [sdtq_pkg::CNT_W-1:0]      count_reg;
    logic [sdtq_pkg::CNT_W-1:0]      count_next;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
            count_next = count_reg + sdtq_pkg::CNT_W'(1);
        else if (cmd.drop)
            count_next = count_reg - sdtq_pkg::CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < sdtq_pkg::DEPTH; i++)
        begin
            if (cmd.insert)
            begin
                if (sdtq_pkg::CNT_W'(i) == cmd.pos)
                begin
                    dl_reg[i] <= cmd.wr_deadline;
                    id_reg[i] <= cmd.wr_id;
                end
                else if (i > 0 && sdtq_pkg::CNT_W'(i) > cmd.pos)
                begin
                    dl_reg[i] <= dl_reg[(i > 0) ? i - 1 : 0];
                    id_reg[i] <= id_reg[(i > 0) ? i - 1 : 0];
                end
            end
            else if (cmd.drop && i < sdtq_pkg::DEPTH - 1)
            begin
                dl_reg[i] <= dl_reg[(i < sdtq_pkg::DEPTH - 1) ? i + 1 : i];
                id_reg[i] <= id_reg[(i < sdtq_pkg::DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_comb
    begin
        stat.count       = count_reg;
        stat.rd_deadline = dl_reg[cmd.rd_idx];
        stat.head_id     = id_reg[0];
    end

endmodule
`default_nettype wire

// ===== rtl/sdtq_ctrl.sv =====
// Sequencer of the timer queue: request intake, position scan through the
// shared compare unit, expiry loop and the result register. Uses sdtq_pkg.
`default_nettype none
module sdtq_ctrl (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [47:0]                     s_tdata,
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [23:0]                          m_tdata,
    output logic [1:0]                           m_tuser,
    output logic                                 m_tlast,
    output sdtq_pkg::store_cmd_t                 cmd,
    input  wire sdtq_pkg::store_stat_t           stat,
    output logic [sdtq_pkg::TIME_WIDTH-1:0]      cmp_deadline,
    output logic [sdtq_pkg::TIME_WIDTH-1:0]      cmp_now,
    output logic [sdtq_pkg::TIME_WIDTH-1:0]      cmp_limit,
    input  wire sdtq_pkg::cmp_flags_t            cmp
);

    sdtq_pkg::state_t state_reg, state_next;

    logic [sdtq_pkg::TIME_WIDTH-1:0] now_reg, now_next;
    logic [sdtq_pkg::TIME_WIDTH-1:0] rem_reg, rem_next;
    logic [sdtq_pkg::ID_WIDTH-1:0]   id_reg, id_next;
    logic [sdtq_pkg::ID_WIDTH-1:0]   pend_reg, pend_next;
    logic [sdtq_pkg::CNT_W-1:0]      idx_reg, idx_next;
    logic [sdtq_pkg::N_W-1:0]        n_reg, n_next;

    logic                            out_valid_reg, out_valid_next;
    logic [sdtq_pkg::RK_W-1:0]       out_kind_reg, out_kind_next;
    logic [sdtq_pkg::ID_WIDTH-1:0]   out_id_reg, out_id_next;
    logic [sdtq_pkg::POS_W-1:0]      out_pos_reg, out_pos_next;
    logic                            out_last_reg, out_last_next;

    logic accept;
    logic out_free;
    logic out_load;
    logic due;
    logic stall;

    assign s_tready = (state_reg == sdtq_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign cmp_deadline = stat.rd_deadline;
    assign cmp_now      = now_reg;
    assign cmp_limit    = rem_reg;

    assign due   = (stat.count != '0) && cmp.zero &&
                   (n_reg != sdtq_pkg::N_W'(sdtq_pkg::MAX_OUT));
    assign stall = (n_reg != '0) && !out_free;

    always_comb
    begin
        state_next    = state_reg;
        now_next      = now_reg;
        rem_next      = rem_reg;
        id_next       = id_reg;
        pend_next     = pend_reg;
        idx_next      = idx_reg;
        n_next        = n_reg;
        out_load      = 1'b0;
        out_kind_next = out_kind_reg;
        out_id_next   = out_id_reg;
        out_pos_next  = out_pos_reg;
        out_last_next = out_last_reg;

        cmd.insert      = 1'b0;
        cmd.drop        = 1'b0;
        cmd.pos         = idx_reg;
        cmd.rd_idx      = (state_reg == sdtq_pkg::ST_SCAN) ?
                          idx_reg[sdtq_pkg::IDX_W-1:0] : '0;
        cmd.wr_deadline = now_reg + rem_reg;
        cmd.wr_id       = id_reg;

        unique case (state_reg)
            sdtq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    rem_next = sdtq_pkg::TIME_WIDTH'(s_tdata[sdtq_pkg::DELAY_W-1:0]);
                    id_next  = sdtq_pkg::ID_WIDTH'(
                        s_tdata[sdtq_pkg::DELAY_W +: sdtq_pkg::IN_ID_W]);
                    idx_next = '0;
                    n_next   = '0;
                    if (s_tuser == sdtq_pkg::KIND_TICK)
                    begin
                        now_next   = now_reg + sdtq_pkg::TIME_WIDTH'(1);
                        state_next = sdtq_pkg::ST_TSCAN;
                    end
                    else if (stat.count == sdtq_pkg::CNT_W'(sdtq_pkg::DEPTH))
                        state_next = sdtq_pkg::ST_REJ;
                    else
                        state_next = sdtq_pkg::ST_SCAN;
                end
            end
            sdtq_pkg::ST_SCAN:
            begin
                if (idx_reg == stat.count || !cmp.le)
                    state_next = sdtq_pkg::ST_INSERT;
                else
                    idx_next = idx_reg + sdtq_pkg::CNT_W'(1);
            end
            sdtq_pkg::ST_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = sdtq_pkg::ST_ACK;
            end
            sdtq_pkg::ST_ACK:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_kind_next = sdtq_pkg::RK_ACCEPT;
                    out_id_next   = id_reg;
                    out_pos_next  = sdtq_pkg::POS_W'(idx_reg);
                    out_last_next = (rem_reg != '0);
                    state_next    = (rem_reg == '0) ? sdtq_pkg::ST_ZEXP
                                                    : sdtq_pkg::ST_IDLE;
                end
            end
            sdtq_pkg::ST_ZEXP:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_kind_next = sdtq_pkg::RK_EXPIRE;
                    out_id_next   = stat.head_id;
                    out_pos_next  = '0;
                    out_last_next = 1'b1;
                    cmd.drop      = 1'b1;
                    state_next    = sdtq_pkg::ST_IDLE;
                end
            end
            sdtq_pkg::ST_REJ:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_kind_next = sdtq_pkg::RK_REJECT;
                    out_id_next   = id_reg;
                    out_pos_next  = '0;
                    out_last_next = 1'b1;
                    state_next    = sdtq_pkg::ST_IDLE;
                end
            end
            sdtq_pkg::ST_TSCAN:
            begin
                // pending expiry goes out once we know whether another follows
                if (!stall)
                begin
                    if (n_reg != '0)
                    begin
                        out_load      = 1'b1;
                        out_kind_next = sdtq_pkg::RK_EXPIRE;
                        out_id_next   = pend_reg;
                        out_pos_next  = '0;
                        out_last_next = !due;
                    end
                    if (due)
                    begin
                        pend_next = stat.head_id;
                        cmd.drop  = 1'b1;
                        n_next    = n_reg + sdtq_pkg::N_W'(1);
                    end
                    else
                        state_next = sdtq_pkg::ST_IDLE;
                end
            end
            default:
                state_next = sdtq_pkg::ST_IDLE;
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdtq_pkg::ST_IDLE;
            now_reg       <= '0;
            n_reg         <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        id_reg       <= id_next;
        pend_reg     <= pend_next;
        out_kind_reg <= out_kind_next;
        out_id_reg   <= out_id_next;
        out_pos_reg  <= out_pos_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_pos_reg, sdtq_pkg::IN_ID_W'(out_id_reg)};

endmodule
`default_nettype wire

// ===== rtl/sorted_deadline_timer_queue.sv =====
// Top level of the sorted deadline timer queue: sequencer, shared compare
// unit and entry store. Uses sdtq_pkg and assert_macros.svh.
//
// Up to 16 timers share one tick counter. A start request is scanned against
// the stored entries one per cycle through a single compare unit, then inserted
// at its sorted position (pos, at most 15) and answered with an accept result,
// followed by an expiry for a zero delay; a start on a full store is rejected.
// A tick request advances the counter and emits one expiry per due timer, up to 16.
// s_tready is high only between requests; results leave through one output
// register, and a stalled m_tready holds the sequencer where it emits.
`default_nettype none
`include "assert_macros.svh"
module sorted_deadline_timer_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // delay_ticks[30:0], timer_id[46:31], pad
    input  wire logic        s_tuser,   // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // expired_id[15:0], position[20:16], pad
    output logic [1:0]       m_tuser,   // result_kind
    output logic             m_tlast    // last
);

    sdtq_pkg::store_cmd_t  cmd;
    sdtq_pkg::store_stat_t stat;
    sdtq_pkg::cmp_flags_t  flags;

    logic [sdtq_pkg::TIME_WIDTH-1:0] cmp_deadline;
    logic [sdtq_pkg::TIME_WIDTH-1:0] cmp_now;
    logic [sdtq_pkg::TIME_WIDTH-1:0] cmp_limit;

    sdtq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .cmd          (cmd),
        .stat         (stat),
        .cmp_deadline (cmp_deadline),
        .cmp_now      (cmp_now),
        .cmp_limit    (cmp_limit),
        .cmp          (flags)
    );

    sdtq_cmp u_cmp (
        .deadline (cmp_deadline),
        .now      (cmp_now),
        .limit    (cmp_limit),
        .flags    (flags)
    );

    sdtq_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n,
        stat.count <= sdtq_pkg::CNT_W'(sdtq_pkg::DEPTH))
    `ASSERT_ALWAYS(a_ins_drop_excl, clk, rst_n, !(cmd.insert && cmd.drop))
    `ASSERT_ALWAYS(a_drop_nonempty, clk, rst_n, !cmd.drop || (stat.count != '0))
    `ASSERT_NEXT(a_insert_grows, clk, rst_n, cmd.insert,
        stat.count == $past(stat.count) + sdtq_pkg::CNT_W'(1))

endmodule
`default_nettype wire

// ===== verif/sorted_deadline_timer_queue_checker.sv =====
`timescale 1ns / 100ps
// Checker for sorted_deadline_timer_queue: keeps its own copy of the timer
// store, predicts every response and compares it with the output stream.
// Depends on sdtq_pkg.
module sorted_deadline_timer_queue_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // delay_ticks[30:0], timer_id[46:31], pad
    input  logic        s_tuser,   // kind
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // expired_id[15:0], position[20:16], pad
    input  logic [1:0]  m_tuser,   // result_kind
    input  logic        m_tlast,   // last
    output int          mismatches,
    output int          outstanding,
    output int          responses_seen,
    output int          expiries_seen,
    output int          rejects_seen
);

    localparam int EXP_SLOTS = 64;

    typedef struct packed {
        logic [sdtq_pkg::RK_W-1:0]     kind;
        logic [sdtq_pkg::ID_WIDTH-1:0] id;
        logic [sdtq_pkg::POS_W-1:0]    pos;
        logic                          last;
    } timer_resp_t;

    logic [sdtq_pkg::TIME_WIDTH-1:0] tick_now;
    logic [sdtq_pkg::TIME_WIDTH-1:0] deadline_q [sdtq_pkg::DEPTH];
    logic [sdtq_pkg::ID_WIDTH-1:0]   id_q [sdtq_pkg::DEPTH];
    int                              live;
    timer_resp_t                     exp_ring [EXP_SLOTS];
    int                              exp_head;
    int                              exp_count;
    int                              n_bad;
    int                              n_seen;
    int                              n_exp;
    int                              n_rej;

    function automatic void owe(logic [sdtq_pkg::RK_W-1:0] k,
                                logic [sdtq_pkg::ID_WIDTH-1:0] id, int pos,
                                logic last);
        timer_resp_t r;
        r.kind = k;
        r.id   = id;
        r.pos  = sdtq_pkg::POS_W'(pos);
        r.last = last;
        if (exp_count < EXP_SLOTS)
        begin
            exp_ring[(exp_head + exp_count) % EXP_SLOTS] = r;
            exp_count++;
        end
        else
            n_bad++;
    endfunction

    function automatic timer_resp_t take_oldest();
        timer_resp_t r;
        r         = exp_ring[exp_head];
        exp_head  = (exp_head + 1) % EXP_SLOTS;
        exp_count--;
        return r;
    endfunction

    function automatic void mark_last();
        if (exp_count > 0)
            exp_ring[(exp_head + exp_count - 1) % EXP_SLOTS].last = 1'b1;
    endfunction

    function automatic void retire_head();
        for (int i = 1; i < live; i++)
        begin
            deadline_q[i-1] = deadline_q[i];
            id_q[i-1]       = id_q[i];
        end
        if (live > 0)
            live--;
    endfunction

    function automatic void serve_request(logic kind, logic [sdtq_pkg::DELAY_W-1:0] dly,
                                          logic [sdtq_pkg::IN_ID_W-1:0] id_in);
        logic [sdtq_pkg::TIME_WIDTH-1:0] rem;
        logic [sdtq_pkg::TIME_WIDTH-1:0] left;
        int                              pos;
        int                              n;
        rem = sdtq_pkg::TIME_WIDTH'(dly);
        if (kind == sdtq_pkg::KIND_START)
        begin
            if (live >= sdtq_pkg::DEPTH)
            begin
                owe(sdtq_pkg::RK_REJECT, id_in, 0, 1'b1);
                return;
            end
            // new entry goes after every entry due at or before it
            pos = 0;
            while (pos < live)
            begin
                left = deadline_q[pos] - tick_now;
                if (left > rem)
                    break;
                pos++;
            end
            for (int i = live; i > pos; i--)
            begin
                deadline_q[i] = deadline_q[i-1];
                id_q[i]       = id_q[i-1];
            end
            deadline_q[pos] = tick_now + rem;
            id_q[pos]       = id_in;
            live++;
            if (rem == 0)
            begin
                owe(sdtq_pkg::RK_ACCEPT, id_in, pos, 1'b0);
                owe(sdtq_pkg::RK_EXPIRE, id_q[0], 0, 1'b1);
                retire_head();
            end
            else
                owe(sdtq_pkg::RK_ACCEPT, id_in, pos, 1'b1);
        end
        else
        begin
            tick_now = tick_now + 1'b1;
            n = 0;
            while (live > 0 && n < sdtq_pkg::MAX_OUT && deadline_q[0] == tick_now)
            begin
                owe(sdtq_pkg::RK_EXPIRE, id_q[0], 0, 1'b0);
                retire_head();
                n++;
            end
            if (n > 0)
                mark_last();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        timer_resp_t want;
        timer_resp_t got;
        if (!rst_n)
        begin
            tick_now  = '0;
            live      = 0;
            n_bad     = 0;
            n_seen    = 0;
            n_exp     = 0;
            n_rej     = 0;
            exp_head  = 0;
            exp_count = 0;
            for (int i = 0; i < sdtq_pkg::DEPTH; i++)
            begin
                deadline_q[i] = '0;
                id_q[i]       = '0;
            end
        end
        else
        begin
            // responses first: one leaving now never belongs to a request taken now
            if (m_tvalid && m_tready)
            begin
                got.kind = m_tuser;
                got.id   = m_tdata[15:0];
                got.pos  = m_tdata[20:16];
                got.last = m_tlast;
                n_seen++;
                if (got.kind == sdtq_pkg::RK_EXPIRE)
                    n_exp++;
                if (got.kind == sdtq_pkg::RK_REJECT)
                    n_rej++;
                if (exp_count == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("%0t: unexpected response kind=%0d id=%h pos=%0d last=%b",
                                 $realtime, got.kind, got.id, got.pos, got.last);
                end
                else
                begin
                    want = take_oldest();
                    if (got.kind != want.kind || got.id != want.id ||
                        got.pos != want.pos || got.last != want.last)
                    begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("%0t: mismatch want %0d/%h/%0d/%b got %0d/%h/%0d/%b",
                                     $realtime, want.kind, want.id, want.pos, want.last,
                                     got.kind, got.id, got.pos, got.last);
                    end
                end
            end
            if (s_tvalid && s_tready)
                serve_request(s_tuser, s_tdata[sdtq_pkg::DELAY_W-1:0],
                              s_tdata[sdtq_pkg::DELAY_W +: sdtq_pkg::IN_ID_W]);
        end
        mismatches     <= n_bad;
        outstanding    <= exp_count;
        responses_seen <= n_seen;
        expiries_seen  <= n_exp;
        rejects_seen   <= n_rej;
    end

endmodule

// ===== verif/sorted_deadline_timer_queue_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for sorted_deadline_timer_queue: clock, reset, request and
// response drivers, watchdog and verdict. Depends on sdtq_pkg and the checker.
module sorted_deadline_timer_queue_tb;

    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_REQS = 108;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // delay_ticks[30:0], timer_id[46:31], pad
    logic        s_tuser;   // kind
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // expired_id[15:0], position[20:16], pad
    logic [1:0]  m_tuser;   // result_kind
    logic        m_tlast;   // last

    int          mismatches;
    int          outstanding;
    int          responses_seen;
    int          expiries_seen;
    int          rejects_seen;

    int          send_idle_pct;
    int          recv_idle_pct;
    logic        hold_req;
    logic        hold_done;
    int          hold_left;
    int          sent;
    int          quiet_cycles;

    sorted_deadline_timer_queue u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sorted_deadline_timer_queue_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .responses_seen (responses_seen),
        .expiries_seen  (expiries_seen),
        .rejects_seen   (rejects_seen)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    // response side: random stalls plus one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_done = 1'b0;
            hold_left = 0;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic offer_request(input logic kind,
                                 input logic [sdtq_pkg::DELAY_W-1:0] dly,
                                 input logic [sdtq_pkg::IN_ID_W-1:0] id);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, id, dly};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic await_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [sdtq_pkg::DELAY_W-1:0] dly;
        rst_n         <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tuser       <= sdtq_pkg::KIND_START;
        s_tdata       <= '0;
        hold_req      <= 1'b0;
        recv_idle_pct <= 66;
        send_idle_pct = 17;
        sent          = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle tick, zero delay, fill with equal deadlines,
        // rejects on a full store, one tick expiring all, longest delay
        offer_request(sdtq_pkg::KIND_TICK, '0, '0);
        offer_request(sdtq_pkg::KIND_START, '0, 16'h0000);
        for (int i = 0; i < sdtq_pkg::DEPTH; i++)
            offer_request(sdtq_pkg::KIND_START, 31'd4, sdtq_pkg::IN_ID_W'($urandom));
        offer_request(sdtq_pkg::KIND_START, '0, 16'h5a5a);
        offer_request(sdtq_pkg::KIND_START, 31'd7, 16'hffff);
        for (int i = 0; i < 4; i++)
            offer_request(sdtq_pkg::KIND_TICK, sdtq_pkg::DELAY_W'($urandom),
                          sdtq_pkg::IN_ID_W'($urandom));
        offer_request(sdtq_pkg::KIND_START, {sdtq_pkg::DELAY_W{1'b1}}, 16'hffff);
        await_drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 66 : 0;
            recv_idle_pct <= (ph == 0) ? 66 : (ph == 1) ? 17 : 0;
            for (int k = 0; k < PHASE_REQS; k++)
            begin
                if (ph == 0 && k == 20)
                    hold_req <= 1'b1;
                if ($urandom_range(99) < 45)
                    offer_request(sdtq_pkg::KIND_TICK, sdtq_pkg::DELAY_W'($urandom),
                                  sdtq_pkg::IN_ID_W'($urandom));
                else
                begin
                    dly = ($urandom_range(9) == 0) ? '0 :
                          sdtq_pkg::DELAY_W'($urandom_range(20, 1));
                    offer_request(sdtq_pkg::KIND_START, dly, sdtq_pkg::IN_ID_W'($urandom));
                end
            end
            await_drain();
        end

        repeat (40) @(posedge clk);
        $display("covered %0d requests: directed corners, then random starts and ticks",
                 sent);
        $display("under three stall mixes; %0d responses checked, %0d expiries, %0d rejects",
                 responses_seen, expiries_seen, rejects_seen);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
